// File: rtl/lad_pkg.sv
// Package for the linear array deque.
// Holds field widths, opcode and status codes, and the sequencer state type.
// No dependencies.
package lad_pkg;

    // Default number of entries
    localparam int LAD_DEPTH = 16;

    // Fixed field widths
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    // Operation codes (code 7 behaves as a query)
    localparam logic [OP_W-1:0] OP_PUSH_TAIL = 3'd0;
    localparam logic [OP_W-1:0] OP_POP_HEAD  = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_HEAD = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_TAIL  = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY     = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd5;
    localparam logic [OP_W-1:0] OP_COMPACT   = 3'd6;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_ROOM = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_RESP,
        S_MOVE
    } state_t;

endpackage

// File: rtl/linear_array_deque.sv
// Linear array deque: top level with entry memory, index registers and sequencer.
// Depends on lad_pkg.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid, in_stall, opcode, push_value          | input item
//  out     | out_valid, out_stall, popped_value, status,     | result item
//          | front_value, back_value, occupancy, full_flag,  |
//          | empty_flag                                      |
//
// Push, pop, query and clear pass through S_RESP: the accept cycle writes the memory
// and issues the reads of the new front and back, the next cycle loads the result.
// Compaction walks the entries in S_MOVE when head is above 0 and entries remain,
// one entry moved per cycle through the single write port of the entry memory,
// the last entry written after its read; else it goes straight to the result.
// Reset clears head, tail and the sequencer; memory contents are not cleared.
// A stalled result holds the output register; a new item is taken in the cycle
// the previous result leaves.
module linear_array_deque
    import lad_pkg::*;
#(
    parameter int DEPTH = LAD_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [OP_W-1:0]          opcode,
    input  logic signed [DATA_W-1:0] push_value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] popped_value,
    output logic [STAT_W-1:0]        status,
    output logic signed [DATA_W-1:0] front_value,
    output logic signed [DATA_W-1:0] back_value,
    output logic [OCC_W-1:0]         occupancy,
    output logic                     full_flag,
    output logic                     empty_flag
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_DEPTH = IDX_W'(DEPTH);
    localparam logic [IDX_W-1:0] IDX_ZERO  = '0;
    localparam logic [IDX_W-1:0] IDX_ONE   = IDX_W'(1);
    localparam logic [ADDR_W-1:0] ADDR_ONE = ADDR_W'(1);

    // Entry memory, one write and two read ports, registered read data
    logic [DATA_W-1:0] mem [DEPTH];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic [DATA_W-1:0] rd_a_reg;
    logic [DATA_W-1:0] rd_b_reg;

    // Control state
    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [ADDR_W-1:0] src_reg, src_next;
    logic [ADDR_W-1:0] dst_reg, dst_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;

    // Payload state
    logic [DATA_W-1:0] front_cache_reg, front_cache_next;
    logic [DATA_W-1:0] back_cache_reg, back_cache_next;
    logic [DATA_W-1:0] fwd_val_reg;
    logic              fwd_a_reg, fwd_a_next;
    logic              fwd_b_reg, fwd_b_next;
    logic [DATA_W-1:0] popped_reg, popped_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0] out_popped_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [DATA_W-1:0] out_front_reg;
    logic [DATA_W-1:0] out_back_reg;
    logic [OCC_W-1:0]  out_occ_reg;
    logic              out_full_reg;
    logic              out_empty_reg;

    // Combinational helpers
    logic              accept;
    logic              load_out;
    logic              cur_empty;
    logic [IDX_W-1:0]  tail_m1;
    logic [DATA_W-1:0] front_now;
    logic [DATA_W-1:0] back_now;
    logic [IDX_W-1:0]  occ_now;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = !((state_reg == S_IDLE) && (!out_valid_reg || !out_stall));
    assign cur_empty = (head_reg == tail_reg);
    assign tail_m1   = tail_next - IDX_ONE;
    assign occ_now   = tail_reg - head_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (opcode == OP_COMPACT) ? S_MOVE : S_RESP;
                end
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            S_MOVE:
            begin
                if ((cnt_reg == IDX_ZERO) && !pend_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Operation decode, index update, memory access and compaction walk
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        popped_next = popped_reg;
        status_next = status_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        cnt_next    = cnt_reg;
        pend_next   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = tail_reg[ADDR_W-1:0];
        mem_wdata   = push_value;
        load_out    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    popped_next = '0;
                    status_next = STAT_OK;
                    case (opcode)
                        OP_PUSH_TAIL:
                        begin
                            if (tail_reg == IDX_DEPTH)
                            begin
                                status_next = STAT_NO_ROOM;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = tail_reg[ADDR_W-1:0];
                                tail_next = tail_reg + IDX_ONE;
                            end
                        end
                        OP_POP_HEAD:
                        begin
                            if (cur_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                popped_next = front_cache_reg;
                                head_next   = head_reg + IDX_ONE;
                            end
                        end
                        OP_PUSH_HEAD:
                        begin
                            if (head_reg == IDX_ZERO)
                            begin
                                status_next = STAT_NO_ROOM;
                            end
                            else
                            begin
                                head_next = head_reg - IDX_ONE;
                                mem_we    = 1'b1;
                                mem_waddr = head_next[ADDR_W-1:0];
                            end
                        end
                        OP_POP_TAIL:
                        begin
                            if (cur_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                popped_next = back_cache_reg;
                                tail_next   = tail_reg - IDX_ONE;
                            end
                        end
                        OP_CLEAR:
                        begin
                            head_next = IDX_ZERO;
                            tail_next = IDX_ZERO;
                        end
                        OP_COMPACT:
                        begin
                            // Entries only move when head is above 0
                            head_next = IDX_ZERO;
                            tail_next = occ_now;
                            src_next  = head_reg[ADDR_W-1:0];
                            dst_next  = '0;
                            cnt_next  = (head_reg == IDX_ZERO) ? IDX_ZERO : occ_now;
                        end
                        default:
                        begin
                            // query and unused code: no change
                        end
                    endcase
                end
            end
            S_RESP:
            begin
                load_out = 1'b1;
            end
            S_MOVE:
            begin
                // Read one source entry per cycle, write it in the following cycle
                if (cnt_reg != IDX_ZERO)
                begin
                    src_next  = src_reg + ADDR_ONE;
                    cnt_next  = cnt_reg - IDX_ONE;
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = dst_reg;
                    mem_wdata = rd_a_reg;
                    dst_next  = dst_reg + ADDR_ONE;
                end
                if ((cnt_reg == IDX_ZERO) && !pend_reg)
                begin
                    load_out = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Read addresses: new front and back, or the compaction source
    assign rd_addr_a = (state_reg == S_MOVE) ? src_reg : head_next[ADDR_W-1:0];
    assign rd_addr_b = tail_m1[ADDR_W-1:0];
    assign fwd_a_next = mem_we && (state_reg == S_IDLE) && (mem_waddr == rd_addr_a);
    assign fwd_b_next = mem_we && (state_reg == S_IDLE) && (mem_waddr == rd_addr_b);

    // Front and back after the operation, with forwarding of the pushed item
    always_comb
    begin
        front_now = fwd_a_reg ? fwd_val_reg : rd_a_reg;
        back_now  = fwd_b_reg ? fwd_val_reg : rd_b_reg;
        front_cache_next = front_cache_reg;
        back_cache_next  = back_cache_reg;
        if (state_reg == S_RESP)
        begin
            front_cache_next = front_now;
            back_cache_next  = back_now;
        end
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Entry memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            src_reg       <= '0;
            dst_reg       <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_a_reg     <= 1'b0;
            fwd_b_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            src_reg       <= src_next;
            dst_reg       <= dst_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            fwd_a_reg     <= fwd_a_next;
            fwd_b_reg     <= fwd_b_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        front_cache_reg <= front_cache_next;
        back_cache_reg  <= back_cache_next;
        popped_reg      <= popped_next;
        status_reg      <= status_next;
        if (accept)
        begin
            fwd_val_reg <= push_value;
        end
        if (load_out)
        begin
            out_popped_reg <= popped_reg;
            out_status_reg <= status_reg;
            out_front_reg  <= cur_empty ? '0 :
                              ((state_reg == S_RESP) ? front_now : front_cache_reg);
            out_back_reg   <= cur_empty ? '0 :
                              ((state_reg == S_RESP) ? back_now : back_cache_reg);
            out_occ_reg    <= OCC_W'(occ_now);
            out_full_reg   <= (head_reg == IDX_ZERO) && (tail_reg == IDX_DEPTH);
            out_empty_reg  <= cur_empty;
        end
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = out_popped_reg;
    assign status       = out_status_reg;
    assign front_value  = out_front_reg;
    assign back_value   = out_back_reg;
    assign occupancy    = out_occ_reg;
    assign full_flag    = out_full_reg;
    assign empty_flag   = out_empty_reg;

endmodule
